// ===== rtl/mbpm_pkg.sv =====
// Package for the masked byte pattern matcher: sizes, register indexes,
// payload structs and the configuration struct used by all modules but the queue.
// Depends on nothing.
package mbpm_pkg;

  localparam int MaxPatternBytes = 16;
  localparam int OffsetWidth     = 32;
  localparam int AddressWidth    = 48;

  localparam int PatternRegBytes = 16;
  localparam int PatMax  = (MaxPatternBytes < PatternRegBytes) ? MaxPatternBytes
                                                               : PatternRegBytes;
  localparam int LenW    = 5;
  localparam int LimitW  = 16;
  localparam int FillW   = $clog2(MaxPatternBytes + 1);
  localparam int CmpW    = (FillW > LenW) ? FillW : LenW;
  localparam int WinIdxW = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegPatternLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPatternHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCareMask    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPatternLen  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegResultLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRegionBase  = 3'd5;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [OffsetWidth-1:0]  match_offset;
    logic [AddressWidth-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [8*PatternRegBytes-1:0] pattern;
    logic [PatternRegBytes-1:0]   care_mask;
    logic [LenW-1:0]              pattern_length;
    logic [LimitW-1:0]            result_limit;
    logic [AddressWidth-1:0]      region_base;
  } cfg_t;

endpackage

// ===== rtl/masked_byte_pattern_matcher.sv =====
// Top level of the masked byte pattern matcher: configuration registers,
// front end, match queue and back end. Depends on mbpm_pkg and all mbpm modules.
//
//   Channel  Handshake                     Payload
//   input    push, full                    in_item_i (data_byte, end_of_buffer)
//   result   empty, pop                    out_item_o (match_offset, match_address)
//   config   cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while full is low; the window compare is done in the cycle of
// acceptance. A match passes through a four-entry queue and the address adder's output
// register before it reaches the result ports.
// Reset clears the configuration, the window, the counters and the queue pointers.
// Full rises only while the match queue holds four waiting results.
module masked_byte_pattern_matcher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  mbpm_pkg::in_item_t           in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output mbpm_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mbpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbpm_pkg::CfgDataW-1:0] cfg_data_i
);

  mbpm_pkg::cfg_t                   cfg;
  logic                             accept;
  logic                             hit;
  logic [mbpm_pkg::OffsetWidth-1:0] hit_offset;
  logic [mbpm_pkg::OffsetWidth-1:0] q_offset;
  logic                             q_full, q_avail, q_take;

  assign full   = q_full;
  assign accept = push && !q_full;

  mbpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbpm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_item_i),
    .hit_o    (hit),
    .offset_o (hit_offset)
  );

  mbpm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hit),
    .wr_data_i (hit_offset),
    .full_o    (q_full),
    .rd_i      (q_take),
    .rd_data_o (q_offset),
    .avail_o   (q_avail)
  );

  mbpm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .avail_i  (q_avail),
    .offset_i (q_offset),
    .take_o   (q_take),
    .empty_o  (empty),
    .pop_i    (pop),
    .out_o    (out_item_o)
  );

endmodule

// ===== rtl/mbpm_cfg.sv =====
// Configuration register file of the masked byte pattern matcher.
// Depends on mbpm_pkg for register indexes and the configuration struct.
module mbpm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mbpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbpm_pkg::CfgDataW-1:0] cfg_data_i,
  output mbpm_pkg::cfg_t               cfg_o
);

  mbpm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mbpm_pkg::RegPatternLow:  cfg_d.pattern[63:0]   = cfg_data_i;
        mbpm_pkg::RegPatternHigh: cfg_d.pattern[127:64] = cfg_data_i;
        mbpm_pkg::RegCareMask:
          cfg_d.care_mask = cfg_data_i[mbpm_pkg::PatternRegBytes-1:0];
        mbpm_pkg::RegPatternLen:
          cfg_d.pattern_length = cfg_data_i[mbpm_pkg::LenW-1:0];
        mbpm_pkg::RegResultLimit:
          cfg_d.result_limit = cfg_data_i[mbpm_pkg::LimitW-1:0];
        mbpm_pkg::RegRegionBase:
          cfg_d.region_base = cfg_data_i[mbpm_pkg::AddressWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/mbpm_front.sv =====
// Front end: byte window, masked compare, buffer offset and match limit.
// Depends on mbpm_pkg; pushes match offsets into the match queue.
module mbpm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mbpm_pkg::cfg_t                   cfg_i,
  input  logic                             accept_i,
  input  mbpm_pkg::in_item_t               item_i,
  output logic                             hit_o,
  output logic [mbpm_pkg::OffsetWidth-1:0] offset_o
);

  logic [7:0] win_q [mbpm_pkg::MaxPatternBytes];
  logic [7:0] win_d [mbpm_pkg::MaxPatternBytes];
  logic [mbpm_pkg::OffsetWidth-1:0] seen_q, seen_d, seen_inc;
  logic [mbpm_pkg::FillW-1:0]       fill_q, fill_d, fill_inc;
  logic [mbpm_pkg::LimitW-1:0]      rep_q, rep_d;
  logic [mbpm_pkg::LenW-1:0]        len_eff;
  logic [mbpm_pkg::WinIdxW-1:0]     idx;
  logic                             mismatch;
  logic                             under_limit;

  always_comb begin
    if (cfg_i.pattern_length > mbpm_pkg::LenW'(mbpm_pkg::PatMax)) begin
      len_eff = mbpm_pkg::LenW'(mbpm_pkg::PatMax);
    end else begin
      len_eff = cfg_i.pattern_length;
    end
  end

  always_comb begin
    win_d[0] = item_i.data_byte;
    for (int i = 1; i < mbpm_pkg::MaxPatternBytes; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  assign seen_inc = seen_q + mbpm_pkg::OffsetWidth'(1);
  assign fill_inc = (fill_q < mbpm_pkg::FillW'(mbpm_pkg::MaxPatternBytes))
                    ? fill_q + mbpm_pkg::FillW'(1) : fill_q;

  always_comb begin
    mismatch = 1'b0;
    idx      = '0;
    for (int k = 0; k < mbpm_pkg::PatMax; k++) begin
      idx = mbpm_pkg::WinIdxW'(len_eff - mbpm_pkg::LenW'(1) - mbpm_pkg::LenW'(k));
      if ((mbpm_pkg::LenW'(k) < len_eff) && cfg_i.care_mask[k] &&
          (cfg_i.pattern[8*k +: 8] != win_d[idx])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign under_limit = (cfg_i.result_limit == '0) || (rep_q < cfg_i.result_limit);
  assign hit_o = accept_i && (len_eff != '0) && !mismatch && under_limit &&
                 (mbpm_pkg::CmpW'(fill_inc) >= mbpm_pkg::CmpW'(len_eff));
  assign offset_o = seen_inc - mbpm_pkg::OffsetWidth'(len_eff);

  always_comb begin
    seen_d = seen_q;
    fill_d = fill_q;
    rep_d  = rep_q;
    if (accept_i) begin
      if (item_i.end_of_buffer) begin
        seen_d = '0;
        fill_d = '0;
        rep_d  = '0;
      end else begin
        seen_d = seen_inc;
        fill_d = fill_inc;
        if (hit_o && (rep_q != '1)) begin
          rep_d = rep_q + mbpm_pkg::LimitW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      fill_q <= '0;
      rep_q  <= '0;
      for (int i = 0; i < mbpm_pkg::MaxPatternBytes; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      seen_q <= seen_d;
      fill_q <= fill_d;
      rep_q  <= rep_d;
      if (accept_i) begin
        for (int i = 0; i < mbpm_pkg::MaxPatternBytes; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

endmodule

// ===== rtl/mbpm_queue.sv =====
// Short queue of match offsets between the front end and the back end.
// Depends on mbpm_pkg for its depth and entry width.
module mbpm_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_i,
  input  logic [mbpm_pkg::OffsetWidth-1:0] wr_data_i,
  output logic                             full_o,
  input  logic                             rd_i,
  output logic [mbpm_pkg::OffsetWidth-1:0] rd_data_o,
  output logic                             avail_o
);

  logic [mbpm_pkg::OffsetWidth-1:0] mem_q [mbpm_pkg::QueueDepth];
  logic [mbpm_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [mbpm_pkg::QueueCntW-1:0]   cnt_q;
  logic                             do_wr, do_rd;

  assign full_o    = (cnt_q == mbpm_pkg::QueueCntW'(mbpm_pkg::QueueDepth));
  assign avail_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == mbpm_pkg::QueuePtrW'(mbpm_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + mbpm_pkg::QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == mbpm_pkg::QueuePtrW'(mbpm_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + mbpm_pkg::QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + mbpm_pkg::QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - mbpm_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/mbpm_back.sv =====
// Back end: adds the region base to each queued offset and holds the result.
// Depends on mbpm_pkg for the result struct and the configuration struct.
module mbpm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mbpm_pkg::cfg_t                   cfg_i,
  input  logic                             avail_i,
  input  logic [mbpm_pkg::OffsetWidth-1:0] offset_i,
  output logic                             take_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output mbpm_pkg::out_item_t              out_o
);

  logic                valid_q;
  mbpm_pkg::out_item_t out_q;

  assign take_o  = avail_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;
  assign out_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q.match_offset  <= offset_i;
      out_q.match_address <= cfg_i.region_base +
                             mbpm_pkg::AddressWidth'(offset_i);
    end
  end

endmodule
